// File: rtl/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg
// Shared widths, register indexes, datapath opcodes and bundles for the
// incremental PID controller with feedforward.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipf_pkg;

  localparam int DATA_W    = 32;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 12;
  localparam int NUM_X     = 4;
  localparam int IN_W      = 7 * DATA_W;
  localparam int IDX_W     = 3;
  localparam int CFG_W     = 64;
  localparam int CNT_W     = 2;

  localparam int PRED_W = 39;
  localparam int B_W    = 40;
  localparam int LO_W   = 20;
  localparam int MB_W   = B_W - LO_W + 1;
  localparam int PROD_W = DATA_W + MB_W;
  localparam int TERM_W = DATA_W + B_W + 1;
  localparam int SAT_W  = 48;
  localparam int ACC_W  = SAT_W + 3;

  localparam logic [IDX_W-1:0] REG_P_GAIN        = 3'd0;
  localparam logic [IDX_W-1:0] REG_I_GAIN        = 3'd1;
  localparam logic [IDX_W-1:0] REG_D_GAIN        = 3'd2;
  localparam logic [IDX_W-1:0] REG_FF_GAIN       = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW_COEFS     = 3'd4;
  localparam logic [IDX_W-1:0] REG_OUT_MIN       = 3'd5;
  localparam logic [IDX_W-1:0] REG_OUT_MAX       = 3'd6;
  localparam logic [IDX_W-1:0] REG_CONTROL_INDEX = 3'd7;

  localparam logic [3:0] OP_NOP  = 4'd0;
  localparam logic [3:0] OP_LOAD = 4'd1;
  localparam logic [3:0] OP_INIT = 4'd2;
  localparam logic [3:0] OP_PMUL = 4'd3;
  localparam logic [3:0] OP_PADD = 4'd4;
  localparam logic [3:0] OP_BSEL = 4'd5;
  localparam logic [3:0] OP_MLO  = 4'd6;
  localparam logic [3:0] OP_MHI  = 4'd7;
  localparam logic [3:0] OP_THI  = 4'd8;
  localparam logic [3:0] OP_TACC = 4'd9;
  localparam logic [3:0] OP_FIN  = 4'd10;
  localparam logic [3:0] OP_HOLD = 4'd11;

  // term order shared by operand and gain select
  localparam logic [CNT_W-1:0] TERM_FF = 2'd0;
  localparam logic [CNT_W-1:0] TERM_I  = 2'd1;
  localparam logic [CNT_W-1:0] TERM_P  = 2'd2;
  localparam logic [CNT_W-1:0] TERM_D  = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] p_gain;
    logic [DATA_W-1:0] i_gain;
    logic [DATA_W-1:0] d_gain;
    logic [DATA_W-1:0] ff_gain;
    logic [CFG_W-1:0]  row_coefs;
    logic [DATA_W-1:0] out_min;
    logic [DATA_W-1:0] out_max;
    logic [1:0]        control_index;
  } cfg_t;

  typedef struct packed {
    logic [3:0]       op;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic is_new;
  } status_t;

endpackage

`default_nettype wire

// File: rtl/ipf_regs.sv
// ----------------------------------------------------------------------------
// ipf_regs
// Configuration register file, written through a valid/ready channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipf_regs (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ipf_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [ipf_pkg::CFG_W-1:0]   cfg_data,
  output ipf_pkg::cfg_t                    cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_gain        <= '0;
      cfg.i_gain        <= '0;
      cfg.d_gain        <= '0;
      cfg.ff_gain       <= '0;
      cfg.row_coefs     <= '0;
      cfg.out_min       <= 32'h8000_0000;
      cfg.out_max       <= 32'h7FFF_FFFF;
      cfg.control_index <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ipf_pkg::REG_P_GAIN:        cfg.p_gain        <= cfg_data[ipf_pkg::DATA_W-1:0];
        ipf_pkg::REG_I_GAIN:        cfg.i_gain        <= cfg_data[ipf_pkg::DATA_W-1:0];
        ipf_pkg::REG_D_GAIN:        cfg.d_gain        <= cfg_data[ipf_pkg::DATA_W-1:0];
        ipf_pkg::REG_FF_GAIN:       cfg.ff_gain       <= cfg_data[ipf_pkg::DATA_W-1:0];
        ipf_pkg::REG_ROW_COEFS:     cfg.row_coefs     <= cfg_data;
        ipf_pkg::REG_OUT_MIN:       cfg.out_min       <= cfg_data[ipf_pkg::DATA_W-1:0];
        ipf_pkg::REG_OUT_MAX:       cfg.out_max       <= cfg_data[ipf_pkg::DATA_W-1:0];
        ipf_pkg::REG_CONTROL_INDEX: cfg.control_index <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/ipf_ctrl.sv
// ----------------------------------------------------------------------------
// ipf_ctrl
// Sequencer: for a new step, steps the shared multiplier through the row sum and
// the four gain terms; then, or at once for a held step, loads the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipf_ctrl #(
  parameter int STATE_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ipf_pkg::status_t  status,
  output ipf_pkg::cmd_t          cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_PMUL   = 4'd2;
  localparam logic [3:0] S_PADD   = 4'd3;
  localparam logic [3:0] S_BSEL   = 4'd4;
  localparam logic [3:0] S_MLO    = 4'd5;
  localparam logic [3:0] S_MHI    = 4'd6;
  localparam logic [3:0] S_THI    = 4'd7;
  localparam logic [3:0] S_TACC   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  localparam logic [ipf_pkg::CNT_W-1:0] LAST_X = ipf_pkg::CNT_W'(STATE_COUNT - 1);

  logic [3:0]                state, state_next;
  logic [ipf_pkg::CNT_W-1:0] cnt, cnt_next;
  logic                      out_valid_next;
  logic                      out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = ipf_pkg::OP_NOP;
    cmd.idx        = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ipf_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_next = '0;
        if (status.is_new) begin
          cmd.op     = ipf_pkg::OP_INIT;
          state_next = S_PMUL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PMUL: begin
        cmd.op     = ipf_pkg::OP_PMUL;
        state_next = S_PADD;
      end
      S_PADD: begin
        cmd.op = ipf_pkg::OP_PADD;
        if (cnt == LAST_X) begin
          cnt_next   = '0;
          state_next = S_BSEL;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_PMUL;
        end
      end
      S_BSEL: begin
        cmd.op     = ipf_pkg::OP_BSEL;
        state_next = S_MLO;
      end
      S_MLO: begin
        cmd.op     = ipf_pkg::OP_MLO;
        state_next = S_MHI;
      end
      S_MHI: begin
        cmd.op     = ipf_pkg::OP_MHI;
        state_next = S_THI;
      end
      S_THI: begin
        cmd.op     = ipf_pkg::OP_THI;
        state_next = S_TACC;
      end
      S_TACC: begin
        cmd.op = ipf_pkg::OP_TACC;
        if (cnt == ipf_pkg::TERM_D) begin
          state_next = S_FIN;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_BSEL;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.op         = status.is_new ? ipf_pkg::OP_FIN : ipf_pkg::OP_HOLD;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTH
  a_idle_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !in_valid) |=> (state == S_IDLE))
    else $error("sequencer left idle without a transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ipf_pkg::OP_FIN || cmd.op == ipf_pkg::OP_HOLD) |-> out_free)
    else $error("output register loaded while holding an untaken result");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ipf_pkg::OP_FIN || cmd.op == ipf_pkg::OP_HOLD) |=> out_valid)
    else $error("result not presented after finish");

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PMUL || state == S_PADD) |-> (cnt <= LAST_X))
    else $error("row index beyond state count");
`endif

endmodule

`default_nettype wire

// File: rtl/ipf_dp.sv
// ----------------------------------------------------------------------------
// ipf_dp
// Datapath: input capture, shared 32x21 multiplier, prediction, term and
// output accumulators, clamp and controller history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipf_dp #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ipf_pkg::cmd_t               cmd,
  input  wire ipf_pkg::cfg_t               cfg,
  input  wire logic [ipf_pkg::IN_W-1:0]    in_data,
  output ipf_pkg::status_t                 status,
  output logic [ipf_pkg::DATA_W-1:0]       out_value,
  output logic                             out_updated
);

  localparam int DW = ipf_pkg::DATA_W;

  logic [DW-1:0]                    step_q;
  logic signed [DW-1:0]             ref_q, fref_q, xs_q;
  logic signed [DW-1:0]             x_q [ipf_pkg::NUM_X];
  logic signed [ipf_pkg::PRED_W-1:0] pred;
  logic signed [ipf_pkg::B_W-1:0]   b;
  logic signed [ipf_pkg::PROD_W-1:0] prod;
  logic signed [ipf_pkg::TERM_W-1:0] term;
  logic signed [ipf_pkg::ACC_W-1:0] acc;
  logic signed [DW-1:0]             e_q;

  logic signed [DW-1:0] prev_output, err_prev, err_prev2;
  logic [DW-1:0]        last_step;

  logic signed [DW-1:0]              x_sel, gain, mul_a;
  logic signed [ipf_pkg::MB_W-1:0]   mul_b;
  logic signed [ipf_pkg::PROD_W-1:0] mul_p;
  logic signed [ipf_pkg::COEF_W-1:0] coef;
  logic signed [DW:0]                diff;
  logic signed [DW-1:0]              e_new;
  logic signed [ipf_pkg::B_W-1:0]    b_next;
  logic signed [ipf_pkg::B_W-1:0]    b_sel_final;
  logic signed [ipf_pkg::TERM_W-1:0] term_sh;
  logic signed [ipf_pkg::SAT_W-1:0]  term_sat;
  logic signed [ipf_pkg::ACC_W-1:0]  prev_ext;
  logic [DW-1:0]                     u_fin, u_hold;

  function automatic logic signed [ipf_pkg::B_W-1:0] ext_b(input logic signed [DW-1:0] v);
    ext_b = {{(ipf_pkg::B_W-DW){v[DW-1]}}, v};
  endfunction

  function automatic logic [DW-1:0] clamp_u(input logic signed [ipf_pkg::ACC_W-1:0] v,
                                            input logic [DW-1:0] mn,
                                            input logic [DW-1:0] mx);
    logic signed [ipf_pkg::ACC_W-1:0] mne, mxe;
    mne = {{(ipf_pkg::ACC_W-DW){mn[DW-1]}}, mn};
    mxe = {{(ipf_pkg::ACC_W-DW){mx[DW-1]}}, mx};
    if (v > mxe) clamp_u = mx;
    else if (v < mne) clamp_u = mn;
    else clamp_u = v[DW-1:0];
  endfunction

  assign status.is_new = (step_q != last_step);

  always_comb begin
    case (cfg.control_index)
      2'd0:    x_sel = in_data[4*DW-1:3*DW];
      2'd1:    x_sel = in_data[5*DW-1:4*DW];
      2'd2:    x_sel = in_data[6*DW-1:5*DW];
      default: x_sel = in_data[7*DW-1:6*DW];
    endcase
  end

  always_comb begin
    case (cmd.idx)
      ipf_pkg::TERM_FF: gain = cfg.ff_gain;
      ipf_pkg::TERM_I:  gain = cfg.i_gain;
      ipf_pkg::TERM_P:  gain = cfg.p_gain;
      default:          gain = cfg.d_gain;
    endcase
  end

  assign coef = cfg.row_coefs[cmd.idx*ipf_pkg::COEF_W +: ipf_pkg::COEF_W];

  always_comb begin
    mul_a = gain;
    mul_b = '0;
    case (cmd.op)
      ipf_pkg::OP_PMUL: begin
        mul_a = x_q[0];
        mul_b = {{(ipf_pkg::MB_W-ipf_pkg::COEF_W){coef[ipf_pkg::COEF_W-1]}}, coef};
      end
      ipf_pkg::OP_MLO: mul_b = {1'b0, b[ipf_pkg::LO_W-1:0]};
      ipf_pkg::OP_MHI: mul_b = {b[ipf_pkg::B_W-1], b[ipf_pkg::B_W-1:ipf_pkg::LO_W]};
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign diff  = {ref_q[DW-1], ref_q} - {xs_q[DW-1], xs_q};
  assign e_new = (diff[DW] != diff[DW-1]) ? {diff[DW], {(DW-1){~diff[DW]}}} : diff[DW-1:0];

  // feedforward operand: forward reference minus prediction
  assign b_next = ext_b(fref_q) -
                  {{(ipf_pkg::B_W-ipf_pkg::PRED_W){pred[ipf_pkg::PRED_W-1]}}, pred};

  // operand for the selected term
  always_comb begin
    case (cmd.idx)
      ipf_pkg::TERM_FF: b_sel_final = b_next;
      ipf_pkg::TERM_I:  b_sel_final = ext_b(e_q);
      ipf_pkg::TERM_P:  b_sel_final = ext_b(e_q) - ext_b(err_prev);
      default: b_sel_final = ext_b(e_q) - (ext_b(err_prev) <<< 1) + ext_b(err_prev2);
    endcase
  end

  // floor of the exact product, then 48-bit saturation
  assign term_sh = term >>> FRAC_BITS;
  always_comb begin
    if (&term_sh[ipf_pkg::TERM_W-1:ipf_pkg::SAT_W-1] ||
        ~|term_sh[ipf_pkg::TERM_W-1:ipf_pkg::SAT_W-1]) begin
      term_sat = term_sh[ipf_pkg::SAT_W-1:0];
    end else begin
      term_sat = {term_sh[ipf_pkg::TERM_W-1], {(ipf_pkg::SAT_W-1){~term_sh[ipf_pkg::TERM_W-1]}}};
    end
  end

  assign prev_ext = {{(ipf_pkg::ACC_W-DW){prev_output[DW-1]}}, prev_output};
  // clamping the unsaturated sum gives the same result as 48-bit saturation first
  assign u_fin    = clamp_u(acc, cfg.out_min, cfg.out_max);
  assign u_hold   = clamp_u(prev_ext, cfg.out_min, cfg.out_max);

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ipf_pkg::OP_LOAD: begin
        step_q <= in_data[DW-1:0];
        ref_q  <= in_data[2*DW-1:DW];
        fref_q <= in_data[3*DW-1:2*DW];
        xs_q   <= x_sel;
        for (int i = 0; i < ipf_pkg::NUM_X; i++) begin
          x_q[i] <= in_data[(i+3)*DW +: DW];
        end
      end
      ipf_pkg::OP_INIT: begin
        e_q  <= e_new;
        pred <= {{(ipf_pkg::PRED_W-DW){xs_q[DW-1]}}, xs_q};
        acc  <= prev_ext;
      end
      ipf_pkg::OP_PMUL: begin
        prod <= mul_p;
        for (int i = 0; i < ipf_pkg::NUM_X - 1; i++) begin
          x_q[i] <= x_q[i+1];
        end
        x_q[ipf_pkg::NUM_X-1] <= x_q[0];
      end
      ipf_pkg::OP_PADD: begin
        pred <= pred + ipf_pkg::PRED_W'(prod >>> ipf_pkg::COEF_FRAC);
      end
      ipf_pkg::OP_BSEL: b <= b_sel_final;
      ipf_pkg::OP_MLO: prod <= mul_p;
      ipf_pkg::OP_MHI: begin
        prod <= mul_p;
        term <= {{(ipf_pkg::TERM_W-ipf_pkg::PROD_W){prod[ipf_pkg::PROD_W-1]}}, prod};
      end
      ipf_pkg::OP_THI: begin
        term <= term + ({{(ipf_pkg::TERM_W-ipf_pkg::PROD_W){prod[ipf_pkg::PROD_W-1]}}, prod}
                        <<< ipf_pkg::LO_W);
      end
      ipf_pkg::OP_TACC: begin
        acc <= acc + {{(ipf_pkg::ACC_W-ipf_pkg::SAT_W){term_sat[ipf_pkg::SAT_W-1]}}, term_sat};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_output <= '0;
      err_prev    <= '0;
      err_prev2   <= '0;
      last_step   <= '0;
    end else begin
      case (cmd.op)
        ipf_pkg::OP_FIN: begin
          prev_output <= u_fin;
          err_prev2   <= err_prev;
          err_prev    <= e_q;
          last_step   <= step_q;
        end
        ipf_pkg::OP_HOLD: prev_output <= u_hold;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ipf_pkg::OP_FIN: begin
        out_value   <= u_fin;
        out_updated <= 1'b1;
      end
      ipf_pkg::OP_HOLD: begin
        out_value   <= u_hold;
        out_updated <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/incremental_pid_feedforward_top.sv
// ----------------------------------------------------------------------------
// incremental_pid_feedforward_top
// Velocity-form PID controller with model-based feedforward, Q16.16 data.
//
//   channel   dir   fields (low bit up)
//   s_axis    in    tdata: step_number, reference, forward_reference,
//                          state_0, state_1, state_2, state_3
//   m_axis    out   tdata: control_value   tuser: updated
//   cfg       in    cfg_index, cfg_data (register write)
//
// New sample: the one shared 32x21 multiplier sets the sequence, with one pass per
// row coefficient and two passes per gain term; a held sample skips the passes.
// A new input is taken only in idle, so samples do not overlap in the sequence.
// Result is on m_axis the cycle after the sequence ends; the next input is
// taken while it waits, and the sequence stalls at its end until it is taken.
// Reset: synchronous, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module incremental_pid_feedforward_top #(
  parameter int STATE_COUNT = 4,
  parameter int FRAC_BITS   = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // step_number, reference, forward_reference, state_0..state_3
  input  wire logic [ipf_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // control_value
  output logic [ipf_pkg::DATA_W-1:0]       m_axis_tdata,
  // updated
  output logic [0:0]                       m_axis_tuser,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ipf_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [ipf_pkg::CFG_W-1:0]   cfg_data
);

  ipf_pkg::cfg_t    cfg;
  ipf_pkg::cmd_t    cmd;
  ipf_pkg::status_t status;

  ipf_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ipf_ctrl #(
    .STATE_COUNT (STATE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ipf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg         (cfg),
    .in_data     (s_axis_tdata),
    .status      (status),
    .out_value   (m_axis_tdata),
    .out_updated (m_axis_tuser[0])
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_incremental_pid_feedforward_top.sv
// ----------------------------------------------------------------------------
// tb_incremental_pid_feedforward_top
// Self-checking bench for the velocity-form PID controller with feedforward.
// Samples go in on s_axis and drive values come out on m_axis. Both sides see
// random gaps and stalls. A cycle-free predictor computes each drive value and
// its updated flag when the sample is taken. Every result is checked field by
// field against the oldest prediction. Registers are rewritten between phases
// while the block is idle: directed corners come first, then random phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_incremental_pid_feedforward_top;

  localparam int STATE_COUNT   = 4;
  localparam int FRAC_BITS     = 16;
  localparam int ACC_BITS      = 48;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 3000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_SAMPLES = 216;

  // field order matches tdata, step_number in the lowest bits
  typedef struct packed {
    logic [ipf_pkg::NUM_X-1:0][ipf_pkg::DATA_W-1:0] state;
    logic [ipf_pkg::DATA_W-1:0]                     forward_reference;
    logic [ipf_pkg::DATA_W-1:0]                     reference;
    logic [ipf_pkg::DATA_W-1:0]                     step_number;
  } sample_t;

  typedef struct packed {
    logic [ipf_pkg::DATA_W-1:0] control_value;
    logic                       updated;
  } drive_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [ipf_pkg::IN_W-1:0]      s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [ipf_pkg::DATA_W-1:0]    m_axis_tdata;
  logic [0:0]                    m_axis_tuser;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [ipf_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [ipf_pkg::CFG_W-1:0]     cfg_data = '0;

  sample_t sample_queue[$];
  drive_t  drive_expected[$];

  ipf_pkg::cfg_t regs_now;
  longint        prev_drive;
  longint        err_last;
  longint        err_last2;
  logic [31:0]   last_step;

  logic [31:0] next_step;
  bit          idle_on;
  bit          in_taken;
  bit          out_taken;
  int          in_gap;
  int          out_stall;
  int          quiet_cycles;
  int          errors;
  drive_t      want;
  drive_t      got;

  incremental_pid_feedforward_top #(
    .STATE_COUNT(STATE_COUNT),
    .FRAC_BITS  (FRAC_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint sat_signed(longint v, int bits);
    longint lim;
    lim = longint'(1) << (bits - 1);
    if (v > lim - 1) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // floor(gain * operand / 2^FRAC_BITS) without overflow, then 48-bit saturate
  function automatic longint gain_term(logic [ipf_pkg::DATA_W-1:0] gain, longint operand);
    longint g;
    longint hi;
    longint lo;
    g  = longint'($signed(gain));
    hi = operand >>> FRAC_BITS;
    lo = operand - (hi <<< FRAC_BITS);
    return sat_signed(g * hi + ((g * lo) >>> FRAC_BITS), ACC_BITS);
  endfunction

  function automatic longint clamp_drive(longint u);
    longint lo_lim;
    longint hi_lim;
    lo_lim = longint'($signed(regs_now.out_min));
    hi_lim = longint'($signed(regs_now.out_max));
    if (u > hi_lim) return hi_lim;
    if (u < lo_lim) return lo_lim;
    return u;
  endfunction

  function automatic drive_t predict_drive(sample_t smp);
    longint x[ipf_pkg::NUM_X];
    longint e;
    longint pred;
    longint acc;
    longint u;
    longint coef;
    int     sel;
    drive_t r;
    for (int i = 0; i < ipf_pkg::NUM_X; i++) x[i] = longint'($signed(smp.state[i]));
    sel = int'(regs_now.control_index);
    if (smp.step_number != last_step) begin
      e    = sat_signed(longint'($signed(smp.reference)) - x[sel], ipf_pkg::DATA_W);
      pred = x[sel];
      for (int i = 0; i < STATE_COUNT; i++) begin
        coef = longint'($signed(regs_now.row_coefs[16*i +: 16]));
        pred += (coef * x[i]) >>> ipf_pkg::COEF_FRAC;
      end
      acc = prev_drive;
      acc += gain_term(regs_now.ff_gain,
                       longint'($signed(smp.forward_reference)) - pred);
      acc += gain_term(regs_now.i_gain, e);
      acc += gain_term(regs_now.p_gain, e - err_last);
      acc += gain_term(regs_now.d_gain, e - 2 * err_last + err_last2);
      u = clamp_drive(sat_signed(acc, ACC_BITS));
      err_last2 = err_last;
      err_last  = e;
      last_step = smp.step_number;
      r.updated = 1'b1;
    end else begin
      u = clamp_drive(prev_drive);
      r.updated = 1'b0;
    end
    prev_drive      = u;
    r.control_value = u[ipf_pkg::DATA_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
      5, 6, 7:       return $urandom;
      8:             return 32'h7FFF_FFFF;
      default:       return 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1, 2, 3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      4:       return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
      5:       return $urandom;
      6:       return 32'h7FFF_FFFF;
      default: return 32'h8000_0000;
    endcase
  endfunction

  task automatic add_sample(input logic [31:0] step, input logic [31:0] ref_v,
                            input logic [31:0] fref, input logic [31:0] x0,
                            input logic [31:0] x1, input logic [31:0] x2,
                            input logic [31:0] x3);
    sample_t smp;
    smp.step_number       = step;
    smp.reference         = ref_v;
    smp.forward_reference = fref;
    smp.state             = {x3, x2, x1, x0};
    sample_queue.push_back(smp);
  endtask

  task automatic add_random_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) next_step = next_step + 1;
    else if (r >= 92) next_step = $urandom;
    add_sample(next_step, rand_word(), rand_word(), rand_word(), rand_word(),
               rand_word(), rand_word());
  endtask

  task automatic write_reg(input logic [ipf_pkg::IDX_W-1:0] idx,
                           input logic [ipf_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ipf_pkg::REG_P_GAIN:    regs_now.p_gain    = value[ipf_pkg::DATA_W-1:0];
      ipf_pkg::REG_I_GAIN:    regs_now.i_gain    = value[ipf_pkg::DATA_W-1:0];
      ipf_pkg::REG_D_GAIN:    regs_now.d_gain    = value[ipf_pkg::DATA_W-1:0];
      ipf_pkg::REG_FF_GAIN:   regs_now.ff_gain   = value[ipf_pkg::DATA_W-1:0];
      ipf_pkg::REG_ROW_COEFS: regs_now.row_coefs = value;
      ipf_pkg::REG_OUT_MIN:   regs_now.out_min   = value[ipf_pkg::DATA_W-1:0];
      ipf_pkg::REG_OUT_MAX:   regs_now.out_max   = value[ipf_pkg::DATA_W-1:0];
      ipf_pkg::REG_CONTROL_INDEX: regs_now.control_index = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] p, input logic [31:0] i_g,
                           input logic [31:0] d, input logic [31:0] ff,
                           input logic [63:0] coefs, input logic [31:0] lo_lim,
                           input logic [31:0] hi_lim, input logic [1:0] sel);
    write_reg(ipf_pkg::REG_P_GAIN, {32'h0, p});
    write_reg(ipf_pkg::REG_I_GAIN, {32'h0, i_g});
    write_reg(ipf_pkg::REG_D_GAIN, {32'h0, d});
    write_reg(ipf_pkg::REG_FF_GAIN, {32'h0, ff});
    write_reg(ipf_pkg::REG_ROW_COEFS, coefs);
    write_reg(ipf_pkg::REG_OUT_MIN, {32'h0, lo_lim});
    write_reg(ipf_pkg::REG_OUT_MAX, {32'h0, hi_lim});
    write_reg(ipf_pkg::REG_CONTROL_INDEX, {62'h0, sel});
  endtask

  task automatic drain();
    while (sample_queue.size() != 0 || s_axis_tvalid || drive_expected.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        s_axis_tdata  <= sample_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    in_taken  = s_axis_tvalid && s_axis_tready;
    out_taken = m_axis_tvalid && m_axis_tready;
    if (in_taken) drive_expected.push_back(predict_drive(s_axis_tdata));
    if (out_taken) begin
      got.control_value = m_axis_tdata;
      got.updated       = m_axis_tuser[0];
      if (drive_expected.size() == 0) begin
        errors++;
        $error("unexpected transaction: control_value %0d, updated %0d",
               $signed(got.control_value), got.updated);
      end else begin
        want = drive_expected.pop_front();
        if (got.control_value !== want.control_value) begin
          errors++;
          $error("control_value: expected %0d, actual %0d",
                 $signed(want.control_value), $signed(got.control_value));
        end
        if (got.updated !== want.updated) begin
          errors++;
          $error("updated: expected %0d, actual %0d", want.updated, got.updated);
        end
      end
    end
    if (in_taken || out_taken || (cfg_valid && cfg_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    regs_now               = '0;
    regs_now.out_min       = 32'h8000_0000;
    regs_now.out_max       = 32'h7FFF_FFFF;
    prev_drive             = 0;
    err_last               = 0;
    err_last2              = 0;
    last_step              = '0;
    next_step              = '0;
    idle_on                = 1'b1;
    in_gap                 = 0;
    out_stall              = 0;
    quiet_cycles           = 0;
    errors                 = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset defaults: step 0 matches the cleared last step, so it is held
    add_sample(32'd0, 32'h0001_0000, 32'h0002_0000, 32'h1234_5678, 32'h8765_4321,
               32'hFFFF_0000, 32'h0000_FFFF);
    add_sample(32'd0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    drain();

    // moderate gains, +/-100.0 limits
    write_all(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0000_2000,
              64'h0100_FF00_0080_F800, 32'hFF9C_0000, 32'h0064_0000, 2'd0);
    add_sample(32'd1, 32'h0003_0000, 32'h0001_0000, 32'h0001_8000, 32'h0000_4000,
               32'hFFFF_C000, 32'h0002_0000);
    add_sample(32'd1, 32'h0003_0000, 32'h0001_0000, 32'h0001_8000, 32'h0000_4000,
               32'hFFFF_C000, 32'h0002_0000);
    // error saturation, both directions
    add_sample(32'd2, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    add_sample(32'd3, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
    add_sample(32'd4, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF);
    add_sample(32'd5, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000);
    add_sample(32'd6, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000);
    add_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_sample(32'd0, 32'h0000_1000, 32'hFFFF_F000, 32'h0, 32'h0, 32'h0, 32'h0);
    add_sample(32'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();

    // extreme gains and coefficients, saturating the 48-bit sum
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              64'h8000_7FFF_8000_7FFF, 32'h8000_0000, 32'h7FFF_FFFF, 2'd3);
    add_sample(32'd10, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000);
    add_sample(32'd11, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h7FFF_FFFF);
    add_sample(32'd12, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000);
    add_sample(32'd13, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_sample(32'd13, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    add_sample(32'd14, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001,
               32'hFFFF_FFFF, 32'h0000_0001);
    drain();

    // inverted limits; the held sample is clamped by the new limits too
    write_all(32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h0001_0000,
              64'h0000_1000_F000_0800, 32'h0005_0000, 32'hFFFB_0000, 2'd2);
    add_sample(32'd14, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    add_sample(32'd15, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'hFFF0_0000, 32'h0);
    add_sample(32'd16, 32'hFFF0_0000, 32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0);
    add_sample(32'd17, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    next_step = 32'd17;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      logic [31:0] a;
      logic [31:0] b;
      logic [63:0] coefs;
      idle_on = (ph % 3 != 1);
      case ($urandom_range(0, 5))
        0: begin
          a = 32'h8000_0000;
          b = 32'h7FFF_FFFF;
        end
        1: begin
          a = $urandom_range(0, 32'h0080_0000);
          b = -$urandom_range(0, 32'h0080_0000);
        end
        default: begin
          a = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
          b = $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
          if ($signed(a) > $signed(b)) {a, b} = {b, a};
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        coefs = {$urandom, $urandom};
      end else begin
        for (int k = 0; k < 4; k++)
          coefs[16*k +: 16] = 16'($urandom_range(0, 16'h1000)) - 16'h0800;
      end
      write_all(rand_gain(), rand_gain(), rand_gain(), rand_gain(), coefs, a, b,
                2'($urandom_range(0, 3)));
      for (int n = 0; n < PHASE_SAMPLES; n++) add_random_sample();
      drain();
    end

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
